// ===== rtl/core/dmc_pkg.sv =====
package dmc_pkg;

  localparam int unsigned LIGHT_W     = 10;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned TMO_W       = 32;
  localparam int unsigned COIL_W      = 4;
  localparam int unsigned DIR_W       = 2;
  localparam int unsigned PHASE_W     = 2;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned REG_IDX_W   = 1;

  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [LIGHT_W-1:0] LIGHT_THR_RST = LIGHT_W'(500);
  localparam logic [TMO_W-1:0]   MOTOR_TMO_RST = TMO_W'(10000);

  localparam logic [REG_IDX_W-1:0] REG_LIGHT_THR = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR_TMO = 1'b1;

  localparam logic [COIL_W-1:0] COIL_FIRST = 4'b0001;
  localparam logic [COIL_W-1:0] COIL_LAST  = 4'b1000;

  typedef enum logic [DIR_W-1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } motor_t;

  typedef struct packed {
    logic                last_mode_button;
    logic                auto_active;
    motor_t              motor_state;
    logic                timeout_flag;
    logic [PHASE_W-1:0]  phase_index;
  } dmc_state_t;

  typedef struct packed {
    logic                mode_button;
    logic                move_button;
    logic                lower_sensor;
    logic                upper_sensor;
    logic [LIGHT_W-1:0]  light_level;
    logic [STAMP_W-1:0]  time_ms;
  } dmc_item_t;

  typedef struct packed {
    logic [COIL_W-1:0]   coil_pattern;
    logic [DIR_W-1:0]    motor_direction;
    logic                manual_led;
    logic                auto_led;
    logic                bottom_led;
    logic                top_led;
    logic                error_led;
  } dmc_res_t;

  typedef struct packed {
    logic [LIGHT_W-1:0]  light_threshold;
    logic [TMO_W-1:0]    motor_timeout_ms;
  } dmc_cfg_t;

endpackage

// ===== rtl/core/dmc_in_if.sv =====
interface dmc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode_button;
  logic                          move_button;
  logic                          lower_sensor;
  logic                          upper_sensor;
  logic [dmc_pkg::LIGHT_W-1:0]   light_level;
  logic [dmc_pkg::STAMP_W-1:0]   time_ms;

  modport source (
    output valid, mode_button, move_button, lower_sensor, upper_sensor,
           light_level, time_ms,
    input  ready
  );

  modport sink (
    input  valid, mode_button, move_button, lower_sensor, upper_sensor,
           light_level, time_ms,
    output ready
  );
endinterface

// ===== rtl/core/dmc_out_if.sv =====
interface dmc_out_if;
  logic                          valid;
  logic                          ready;
  logic [dmc_pkg::COIL_W-1:0]    coil_pattern;
  logic [dmc_pkg::DIR_W-1:0]     motor_direction;
  logic                          manual_led;
  logic                          auto_led;
  logic                          bottom_led;
  logic                          top_led;
  logic                          error_led;

  modport source (
    output valid, coil_pattern, motor_direction, manual_led, auto_led,
           bottom_led, top_led, error_led,
    input  ready
  );

  modport sink (
    input  valid, coil_pattern, motor_direction, manual_led, auto_led,
           bottom_led, top_led, error_led,
    output ready
  );
endinterface

// ===== rtl/core/door_motor_controller.sv =====
// door motor controller: one control tick per input transaction
//
// in_ch carries one tick: button and limit-sensor levels, light reading
// and millisecond timestamp. out_ch returns exactly one result per tick:
// coil drive pattern, motor direction and the five LED levels.
// the APB port sets the day threshold and the motor run timeout; write
// it only while no tick is in flight.
//
// a tick is captured in an input register, evaluated by one pass of
// combinational logic against the controller state, and lands in the
// output register together with the state update. throughput is one tick
// per cycle while out_ch.ready stays high; the state feedback through the
// step logic sets that figure.
//
// reset puts the controller in automatic mode with the motor stopped, the
// error flag clear, both pipeline registers empty and the registers at
// their defaults (threshold 500, timeout 10000 ms). when out_ch.ready is
// low the result holds, one further tick waits in the input register,
// then in_ch.ready drops until the result is taken.
module door_motor_controller #(
  parameter int unsigned TIME_BITS = dmc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dmc_in_if.sink                          in_ch,
  dmc_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dmc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dmc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dmc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned SW = (TIME_BITS < dmc_pkg::STAMP_W) ? TIME_BITS : dmc_pkg::STAMP_W;

  dmc_pkg::dmc_cfg_t    cfg;
  dmc_pkg::dmc_item_t   item_r;
  logic                 item_v_r;
  dmc_pkg::dmc_state_t  st_r;
  dmc_pkg::dmc_state_t  st_nxt;
  logic [SW-1:0]        start_r;
  logic [SW-1:0]        start_nxt;
  dmc_pkg::dmc_res_t    res_r;
  dmc_pkg::dmc_res_t    res_nxt;
  logic                 res_v_r;
  logic                 adv;
  logic                 in_take;

  dmc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmc_step #(
    .TIME_BITS (TIME_BITS),
    .SW        (SW)
  ) u_step (
    .item      (item_r),
    .st        (st_r),
    .start_r   (start_r),
    .cfg       (cfg),
    .st_nxt    (st_nxt),
    .start_nxt (start_nxt),
    .res       (res_nxt)
  );

  assign adv         = item_v_r && (!res_v_r || out_ch.ready);
  assign in_ch.ready = !item_v_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r                 <= 1'b0;
      res_v_r                  <= 1'b0;
      st_r.last_mode_button    <= 1'b0;
      st_r.auto_active         <= 1'b1;
      st_r.motor_state         <= dmc_pkg::MOTOR_STOP;
      st_r.timeout_flag        <= 1'b0;
      st_r.phase_index         <= '0;
      start_r                  <= '0;
    end else begin
      if (in_take) begin
        item_v_r <= 1'b1;
      end else if (adv) begin
        item_v_r <= 1'b0;
      end
      if (adv) begin
        res_v_r <= 1'b1;
        st_r    <= st_nxt;
        start_r <= start_nxt;
      end else if (out_ch.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode_button  <= in_ch.mode_button;
      item_r.move_button  <= in_ch.move_button;
      item_r.lower_sensor <= in_ch.lower_sensor;
      item_r.upper_sensor <= in_ch.upper_sensor;
      item_r.light_level  <= in_ch.light_level;
      item_r.time_ms      <= in_ch.time_ms;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = res_v_r;
  assign out_ch.coil_pattern    = res_r.coil_pattern;
  assign out_ch.motor_direction = res_r.motor_direction;
  assign out_ch.manual_led      = res_r.manual_led;
  assign out_ch.auto_led        = res_r.auto_led;
  assign out_ch.bottom_led      = res_r.bottom_led;
  assign out_ch.top_led         = res_r.top_led;
  assign out_ch.error_led       = res_r.error_led;

endmodule

// ===== rtl/core/dmc_cfg.sv =====
module dmc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dmc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dmc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dmc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output dmc_pkg::dmc_cfg_t                  cfg
);

  logic [dmc_pkg::LIGHT_W-1:0]   thr_r;
  logic [dmc_pkg::TMO_W-1:0]     tmo_r;
  logic [dmc_pkg::REG_IDX_W-1:0] idx;
  logic                          wr_en;

  assign idx    = paddr[dmc_pkg::APB_ADDR_W-1 -: dmc_pkg::REG_IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= dmc_pkg::LIGHT_THR_RST;
      tmo_r <= dmc_pkg::MOTOR_TMO_RST;
    end else if (wr_en) begin
      case (idx)
        dmc_pkg::REG_LIGHT_THR: thr_r <= pwdata[dmc_pkg::LIGHT_W-1:0];
        dmc_pkg::REG_MOTOR_TMO: tmo_r <= pwdata[dmc_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dmc_pkg::REG_LIGHT_THR: prdata = dmc_pkg::APB_DATA_W'(thr_r);
      dmc_pkg::REG_MOTOR_TMO: prdata = dmc_pkg::APB_DATA_W'(tmo_r);
      default:                prdata = '0;
    endcase
  end

  assign cfg.light_threshold  = thr_r;
  assign cfg.motor_timeout_ms = tmo_r;

endmodule

// ===== rtl/core/dmc_step.sv =====
module dmc_step #(
  parameter int unsigned TIME_BITS = dmc_pkg::TIME_BITS_DEF,
  parameter int unsigned SW        = (TIME_BITS < dmc_pkg::STAMP_W) ?
                                     TIME_BITS : dmc_pkg::STAMP_W
) (
  input  dmc_pkg::dmc_item_t   item,
  input  dmc_pkg::dmc_state_t  st,
  input  logic [SW-1:0]        start_r,
  input  dmc_pkg::dmc_cfg_t    cfg,
  output dmc_pkg::dmc_state_t  st_nxt,
  output logic [SW-1:0]        start_nxt,
  output dmc_pkg::dmc_res_t    res
);

  localparam int unsigned CW = (TIME_BITS > dmc_pkg::TMO_W) ? TIME_BITS : dmc_pkg::TMO_W;

  logic                      auto_now;
  logic                      day;
  logic [SW-1:0]             now;
  logic [TIME_BITS-1:0]      elapsed;
  logic                      to_hit;
  logic                      open_req;
  logic                      close_req;
  dmc_pkg::motor_t           m0;
  dmc_pkg::motor_t           m1;
  dmc_pkg::motor_t           m2;
  dmc_pkg::motor_t           m3;
  logic                      tf1;
  logic                      tf2;
  logic [dmc_pkg::COIL_W-1:0] coils;

  always_comb begin
    auto_now = st.auto_active ^ (item.mode_button & ~st.last_mode_button);
    day      = item.light_level > cfg.light_threshold;
    now      = item.time_ms[SW-1:0];

    case (st.motor_state)
      dmc_pkg::MOTOR_OPEN:  m0 = dmc_pkg::MOTOR_OPEN;
      dmc_pkg::MOTOR_CLOSE: m0 = dmc_pkg::MOTOR_CLOSE;
      default:              m0 = dmc_pkg::MOTOR_STOP;
    endcase

    // elapsed run time wraps at the time counter width
    elapsed = TIME_BITS'(now) - TIME_BITS'(start_r);
    to_hit  = (m0 != dmc_pkg::MOTOR_STOP) && !st.timeout_flag &&
              (CW'(elapsed) > CW'(cfg.motor_timeout_ms));
    m1      = to_hit ? dmc_pkg::MOTOR_STOP : m0;
    tf1     = st.timeout_flag | to_hit;

    if (!auto_now) begin
      open_req  = item.move_button && item.lower_sensor && !item.upper_sensor;
      close_req = item.move_button && item.upper_sensor && !item.lower_sensor;
    end else begin
      open_req  = day && item.lower_sensor && !item.upper_sensor;
      close_req = !day && item.upper_sensor && !item.lower_sensor;
    end

    m2        = m1;
    tf2       = tf1;
    start_nxt = start_r;
    if (open_req) begin
      m2        = dmc_pkg::MOTOR_OPEN;
      tf2       = 1'b0;
      start_nxt = now;
    end else if (close_req) begin
      m2        = dmc_pkg::MOTOR_CLOSE;
      tf2       = 1'b0;
      start_nxt = now;
    end

    // limit sensors
    if ((m2 == dmc_pkg::MOTOR_OPEN && item.upper_sensor) ||
        (m2 == dmc_pkg::MOTOR_CLOSE && item.lower_sensor)) begin
      m3 = dmc_pkg::MOTOR_STOP;
    end else begin
      m3 = m2;
    end

    case (m3)
      dmc_pkg::MOTOR_OPEN:  coils = dmc_pkg::COIL_FIRST << st.phase_index;
      dmc_pkg::MOTOR_CLOSE: coils = dmc_pkg::COIL_LAST >> st.phase_index;
      default:              coils = '0;
    endcase

    st_nxt.last_mode_button = item.mode_button;
    st_nxt.auto_active      = auto_now;
    st_nxt.motor_state      = m3;
    st_nxt.timeout_flag     = tf2;
    st_nxt.phase_index      = (m3 != dmc_pkg::MOTOR_STOP) ?
                              st.phase_index + dmc_pkg::PHASE_W'(1) : st.phase_index;

    res.coil_pattern    = coils;
    res.motor_direction = m3;
    res.manual_led      = ~auto_now;
    res.auto_led        = auto_now;
    res.bottom_led      = item.lower_sensor;
    res.top_led         = item.upper_sensor;
    res.error_led       = st.timeout_flag;
  end

endmodule

// ===== rtl/core/dmc_checker.sv =====
module dmc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [dmc_pkg::COIL_W-1:0]    coil_pattern,
  input  logic [dmc_pkg::DIR_W-1:0]     motor_direction,
  input  logic                          manual_led,
  input  logic                          auto_led,
  input  logic                          bottom_led,
  input  logic                          top_led
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(coil_pattern) &&
    $stable(motor_direction))
    else $error("result changed while stalled");

  a_coil_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((motor_direction == dmc_pkg::MOTOR_STOP) == (coil_pattern == '0)) &&
    $onehot0(coil_pattern))
    else $error("coil pattern does not match motor direction");

  a_mode_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (manual_led != auto_led))
    else $error("mode leds not exclusive");

  a_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((motor_direction == dmc_pkg::MOTOR_OPEN) && top_led) &&
    !((motor_direction == dmc_pkg::MOTOR_CLOSE) && bottom_led))
    else $error("motor runs into an active limit sensor");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (motor_direction == dmc_pkg::MOTOR_STOP) ||
    (motor_direction == dmc_pkg::MOTOR_OPEN) || (motor_direction == dmc_pkg::MOTOR_CLOSE))
    else $error("unused motor code on output");

endmodule

bind door_motor_controller dmc_checker u_dmc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .coil_pattern    (out_ch.coil_pattern),
  .motor_direction (out_ch.motor_direction),
  .manual_led      (out_ch.manual_led),
  .auto_led        (out_ch.auto_led),
  .bottom_led      (out_ch.bottom_led),
  .top_led         (out_ch.top_led)
);
